// ===== rtl/assert_macros.svh =====
// Assertion macros for the stencil RTL; used by the job queue.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ghs_pkg.sv =====
// Package for the gradient and Hessian stencil: widths, reset values, codes and helpers.
// Used by the front end, the back end and the top level; depends on nothing.
`timescale 1ns / 1ps

package ghs_pkg;

	// Grid limits and register reset values.
	localparam int MAX_GRID_DEF = 1024;
	localparam int GRID_MIN     = 5;
	localparam int GS_W         = 11;
	localparam int RCP_W        = 32;
	localparam int CFG_IDX_W    = 2;
	localparam logic [GS_W-1:0]  GRID_RESET         = 11'd1024;
	localparam logic [RCP_W-1:0] RECIP_TWO_RESET    = 32'd32768;
	localparam logic [RCP_W-1:0] RECIP_TWELVE_RESET = 32'd5461;

	// Datapath widths.
	localparam int SAMPLE_W = 32;
	localparam int LANES    = 4;
	localparam int WIN      = 5;
	localparam int NUM_W    = 39;
	localparam int MAG_W    = 38;
	localparam int PROD_W   = MAG_W + RCP_W;
	localparam int FRAC_W   = 16;
	localparam int SC_W     = 56;
	localparam int SQ_W     = 56;
	localparam int RAD_W    = 2 * SQ_W + 1;
	localparam int ROOT_W   = 57;
	localparam int OUT_W    = 48;
	localparam int SAT_IN_W = 60;
	localparam int QDEPTH   = 2;

	// Stencil weights.
	localparam logic signed [NUM_W-1:0] C16 = 39'sd16;
	localparam logic signed [NUM_W-1:0] C30 = 39'sd30;

	localparam logic [PROD_W:0] ROUND_HALF = (PROD_W+1)'(1) << (FRAC_W - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_SIZE    = 2'd0,
		CFG_RECIP_TWO    = 2'd1,
		CFG_RECIP_TWELVE = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_UPDATE,
		FR_EVAL
	} fr_state_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCALE,
		BK_SQ_GO,
		BK_SQUARE,
		BK_ROOT,
		BK_DONE
	} bk_state_t;

	// Exact stencil sums for one interior point.
	typedef struct packed {
		logic signed [NUM_W-1:0] dx;
		logic signed [NUM_W-1:0] dy;
		logic signed [NUM_W-1:0] nxx;
		logic signed [NUM_W-1:0] nyy;
		logic signed [NUM_W-1:0] nxy;
	} num_t;

	// Magnitude of a stencil sum.
	function automatic logic [MAG_W-1:0] num_mag(input logic signed [NUM_W-1:0] v);
		logic [NUM_W-1:0] a;
		a = v[NUM_W-1] ? NUM_W'(-v) : NUM_W'(v);
		return a[MAG_W-1:0];
	endfunction

	// Round a Q54.16 product magnitude to nearest, ties away from zero, then apply the sign.
	function automatic logic signed [SC_W-1:0] scale_round(input logic [PROD_W-1:0] prod,
			input logic neg);
		logic [PROD_W:0] rnd;
		logic [SC_W-1:0] m;
		rnd = {1'b0, prod} + ROUND_HALF;
		m = {1'b0, rnd[PROD_W:FRAC_W]};
		return neg ? SC_W'(-m) : SC_W'(m);
	endfunction

	// Clamp to the signed 48-bit output range.
	function automatic logic signed [OUT_W-1:0] sat48(input logic signed [SAT_IN_W-1:0] v);
		logic [SAT_IN_W-OUT_W:0] hi_bits;
		hi_bits = v[SAT_IN_W-1:OUT_W-1];
		if (hi_bits == '0 || hi_bits == '1) begin
			return v[OUT_W-1:0];
		end else if (v[SAT_IN_W-1]) begin
			return {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			return {1'b0, {(OUT_W-1){1'b1}}};
		end
	endfunction

endpackage

// ===== rtl/ghs_sermul.sv =====
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
// Uses no package; instantiated by the stencil back end.
`timescale 1ns / 1ps

module ghs_sermul #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic             done,
	output logic [AW+BW-1:0] product
);

	localparam int CNTW = $clog2(BW + 1);

	logic [AW+BW-1:0] acc_q;
	logic [AW-1:0]    mcand_q;
	logic [BW-1:0]    mpl_q;
	logic [CNTW-1:0]  cnt_q;
	logic             done_q;
	logic [AW:0]      sum;

	// Add the multiplicand into the upper half when the current multiplier bit is set.
	assign sum = {1'b0, acc_q[AW+BW-1:BW]} + (mpl_q[0] ? {1'b0, mcand_q} : '0);

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && (cnt_q == CNTW'(1));
			if (start) begin
				cnt_q <= CNTW'(BW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// The multiplier and the partial product shift right by one each step.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q   <= '0;
			mcand_q <= a;
			mpl_q   <= b;
		end else if (cnt_q != '0) begin
			acc_q <= {sum, acc_q[BW-1:1]};
			mpl_q <= mpl_q >> 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ===== rtl/ghs_isqrt.sv =====
// Digit-by-digit floor square root, one result bit per cycle.
// Uses no package; instantiated by the stencil back end.
`timescale 1ns / 1ps

module ghs_isqrt #(
	parameter int RT = 57
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [2*RT-1:0]   radicand,
	output logic              done,
	output logic [RT-1:0]     root
);

	localparam int RW   = 2 * RT;
	localparam int RM   = RT + 2;
	localparam int CNTW = $clog2(RT + 1);

	logic [RW-1:0]   rad_q;
	logic [RM-1:0]   rem_q;
	logic [RT-1:0]   root_q;
	logic [CNTW-1:0] cnt_q;
	logic            done_q;
	logic [RM+1:0]   rem_sh;
	logic [RM+1:0]   trial;
	logic [RM+1:0]   diff;
	logic            ge;

	// Bring down the next two radicand bits and try the next root bit.
	assign rem_sh = {rem_q, rad_q[RW-1:RW-2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;
	assign diff   = rem_sh - trial;

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && (cnt_q == CNTW'(1));
			if (start) begin
				cnt_q <= CNTW'(RT);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Remainder, root and radicand shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? diff[RM-1:0] : rem_sh[RM-1:0];
			root_q <= {root_q[RT-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== rtl/ghs_queue.sv =====
// Short job queue between the stencil front end and the arithmetic back end.
// Generic in width and depth; uses assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ghs_queue #(
	parameter int DW    = 32,
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	output logic          full,
	input  logic          pop,
	output logic [DW-1:0] pop_data,
	output logic          nempty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DW-1:0] slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage slots.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	assign full     = count_q == CW'(DEPTH);
	assign nempty   = count_q != '0;
	assign pop_data = slot_q[rd_ptr_q];

	`ASSERT_ALWAYS(a_no_push_full, !(push && full), "job pushed into a full queue")
	`ASSERT_ALWAYS(a_no_pop_empty, !(pop && !nempty), "job popped from an empty queue")
	`ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1, "fill count lost a job")

endmodule

// ===== rtl/ghs_front.sv =====
// Stencil front end: raster counters, line store, 5x5 window and the exact stencil sums.
// Depends on ghs_pkg; feeds jobs to ghs_queue.
`timescale 1ns / 1ps

module ghs_front #(
	parameter int MAX_GRID = ghs_pkg::MAX_GRID_DEF,
	parameter int CW       = $clog2(MAX_GRID)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [ghs_pkg::SAMPLE_W-1:0]  sample,
	input  logic [ghs_pkg::GS_W-1:0]             grid_size,
	output logic                                 push,
	input  logic                                 full,
	output ghs_pkg::num_t                        push_num,
	output logic [CW-1:0]                        push_row,
	output logic [CW-1:0]                        push_col,
	output logic                                 push_last
);

	localparam int NW = CW + 1;
	localparam int SW = ghs_pkg::SAMPLE_W;
	localparam int LW = ghs_pkg::LANES * ghs_pkg::SAMPLE_W;
	localparam int WN = ghs_pkg::WIN;
	localparam int NM = ghs_pkg::NUM_W;

	ghs_pkg::fr_state_t state_q, state_d;

	logic [LW-1:0]        mem [MAX_GRID];
	logic [LW-1:0]        rd_s1;
	logic signed [SW-1:0] sample_s1;
	logic [CW-1:0]        r_s1, c_s1;
	logic                 emit_s1, last_s1;
	logic [CW-1:0]        row_q, col_q;
	logic signed [SW-1:0] win_q [WN][WN];

	logic [NW-1:0]        n;
	logic [CW-1:0]        r_w, c_w;
	logic [NW-1:0]        r_inc, c_inc;
	logic                 accept;
	logic signed [SW-1:0] col_vals [WN];
	logic [LW-1:0]        wr_word;

	function automatic logic signed [NM-1:0] ext(input logic signed [SW-1:0] v);
		return NM'(v);
	endfunction

	// Effective grid size, clamped to the supported range.
	always_comb begin
		if (grid_size < ghs_pkg::GS_W'(ghs_pkg::GRID_MIN)) begin
			n = NW'(ghs_pkg::GRID_MIN);
		end else if (32'(grid_size) > MAX_GRID) begin
			n = NW'(MAX_GRID);
		end else begin
			n = NW'(grid_size);
		end
	end

	// Current raster position, wrapped when the size shrank under it.
	assign r_w    = ({1'b0, row_q} >= n) ? '0 : row_q;
	assign c_w    = ({1'b0, col_q} >= n) ? '0 : col_q;
	assign r_inc  = {1'b0, r_w} + 1'b1;
	assign c_inc  = {1'b0, c_w} + 1'b1;
	assign accept = in_valid && in_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ghs_pkg::FR_IDLE: begin
				if (accept) begin
					state_d = ghs_pkg::FR_UPDATE;
				end
			end
			ghs_pkg::FR_UPDATE: begin
				state_d = emit_s1 ? ghs_pkg::FR_EVAL : ghs_pkg::FR_IDLE;
			end
			ghs_pkg::FR_EVAL: begin
				if (!full) begin
					state_d = ghs_pkg::FR_IDLE;
				end
			end
			default: state_d = ghs_pkg::FR_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		in_ready = 1'b0;
		push     = 1'b0;
		unique case (state_q)
			ghs_pkg::FR_IDLE:   in_ready = 1'b1;
			ghs_pkg::FR_UPDATE: ;
			ghs_pkg::FR_EVAL:   push = !full;
			default:            ;
		endcase
	end

	// Control registers: state, raster counters and per-item flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ghs_pkg::FR_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			emit_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				emit_s1 <= (r_w >= CW'(4)) && (c_w >= CW'(4));
				last_s1 <= (r_inc == n) && (c_inc == n);
				if (c_inc >= n) begin
					col_q <= '0;
					row_q <= (r_inc >= n) ? '0 : r_inc[CW-1:0];
				end else begin
					col_q <= c_inc[CW-1:0];
				end
			end
		end
	end

	// Column of samples entering the window: four stored rows, then the new sample.
	always_comb begin
		for (int k = 0; k < ghs_pkg::LANES; k++) begin
			col_vals[k] = rd_s1[k*SW +: SW];
		end
		col_vals[WN-1] = sample_s1;
		for (int k = 0; k < ghs_pkg::LANES; k++) begin
			wr_word[k*SW +: SW] = col_vals[k+1];
		end
	end

	// Line store: read the column on accept, write it back shifted up one row.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1     <= mem[c_w];
			sample_s1 <= sample;
			r_s1      <= r_w;
			c_s1      <= c_w;
		end
		if (state_q == ghs_pkg::FR_UPDATE) begin
			mem[c_s1] <= wr_word;
		end
	end

	// Window shifts left by one column per sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int y = 0; y < WN; y++) begin
				for (int x = 0; x < WN; x++) begin
					win_q[y][x] <= '0;
				end
			end
		end else if (state_q == ghs_pkg::FR_UPDATE) begin
			for (int y = 0; y < WN; y++) begin
				for (int x = 0; x < WN - 1; x++) begin
					win_q[y][x] <= win_q[y][x+1];
				end
				win_q[y][WN-1] <= col_vals[y];
			end
		end
	end

	// Exact stencil sums around the window center win_q[2][2].
	always_comb begin
		push_num.dx  = ext(win_q[2][3]) - ext(win_q[2][1]);
		push_num.dy  = ext(win_q[3][2]) - ext(win_q[1][2]);
		push_num.nxx = -ext(win_q[2][4]) + ghs_pkg::C16 * ext(win_q[2][3])
			- ghs_pkg::C30 * ext(win_q[2][2]) + ghs_pkg::C16 * ext(win_q[2][1])
			- ext(win_q[2][0]);
		push_num.nyy = -ext(win_q[4][2]) + ghs_pkg::C16 * ext(win_q[3][2])
			- ghs_pkg::C30 * ext(win_q[2][2]) + ghs_pkg::C16 * ext(win_q[1][2])
			- ext(win_q[0][2]);
		push_num.nxy = -ext(win_q[4][4]) + ext(win_q[4][0]) + ext(win_q[0][4])
			- ext(win_q[0][0])
			+ ghs_pkg::C16 * (ext(win_q[3][3]) - ext(win_q[3][1])
			- ext(win_q[1][3]) + ext(win_q[1][1]));
	end

	assign push_row  = r_s1 - CW'(2);
	assign push_col  = c_s1 - CW'(2);
	assign push_last = last_s1;

endmodule

// ===== rtl/ghs_back.sv =====
// Stencil back end: reciprocal scaling, squares, square root, eigenvalues and the result register.
// Depends on ghs_pkg, ghs_sermul and ghs_isqrt.
`timescale 1ns / 1ps

module ghs_back #(
	parameter int CW = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	output logic                                q_pop,
	input  ghs_pkg::num_t                       q_num,
	input  logic [CW-1:0]                       q_row,
	input  logic [CW-1:0]                       q_col,
	input  logic                                q_last,
	input  logic [ghs_pkg::RCP_W-1:0]           recip_two,
	input  logic [ghs_pkg::RCP_W-1:0]           recip_twelve,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [CW-1:0]                       row,
	output logic [CW-1:0]                       col,
	output logic signed [ghs_pkg::OUT_W-1:0]    grad_x,
	output logic signed [ghs_pkg::OUT_W-1:0]    grad_y,
	output logic signed [ghs_pkg::OUT_W-1:0]    eig_plus,
	output logic signed [ghs_pkg::OUT_W-1:0]    eig_minus,
	output logic                                last_point
);

	localparam int MW = ghs_pkg::MAG_W;
	localparam int RW = ghs_pkg::RCP_W;
	localparam int PW = ghs_pkg::PROD_W;
	localparam int SW = ghs_pkg::SC_W;
	localparam int QW = ghs_pkg::SQ_W;
	localparam int TW = ghs_pkg::ROOT_W;
	localparam int XW = ghs_pkg::SAT_IN_W;

	ghs_pkg::bk_state_t state_q, state_d;

	logic               sc_start, sq_start, rt_start, load;
	logic [4:0]         sc_done_v;
	logic [1:0]         sq_done_v;
	logic               sc_done, sq_done, rt_done;
	logic [PW-1:0]      p_gx, p_gy, p_xx, p_yy, p_xy;
	logic [2*QW-1:0]    p_d, p_m;
	logic [TW-1:0]      root;
	logic [4:0]         neg_q;
	logic [CW-1:0]      row_q, col_q;
	logic               last_q;
	logic signed [SW-1:0] gx_q, gy_q, fxx_q, fyy_q, fxy_q;
	logic signed [SW:0] d_w, m_w, s_w;
	logic [SW:0]        d_abs, m_abs;
	logic [ghs_pkg::RAD_W-1:0] rad_w;
	logic out_valid_q;

	// Reciprocal scaling of the five stencil sums.
	ghs_sermul #(.AW(MW), .BW(RW)) u_mul_gx (
		.clk(clk), .arst_n(arst_n), .start(sc_start), .a(ghs_pkg::num_mag(q_num.dx)),
		.b(recip_two), .done(sc_done_v[0]), .product(p_gx));
	ghs_sermul #(.AW(MW), .BW(RW)) u_mul_gy (
		.clk(clk), .arst_n(arst_n), .start(sc_start), .a(ghs_pkg::num_mag(q_num.dy)),
		.b(recip_two), .done(sc_done_v[1]), .product(p_gy));
	ghs_sermul #(.AW(MW), .BW(RW)) u_mul_xx (
		.clk(clk), .arst_n(arst_n), .start(sc_start), .a(ghs_pkg::num_mag(q_num.nxx)),
		.b(recip_twelve), .done(sc_done_v[2]), .product(p_xx));
	ghs_sermul #(.AW(MW), .BW(RW)) u_mul_yy (
		.clk(clk), .arst_n(arst_n), .start(sc_start), .a(ghs_pkg::num_mag(q_num.nyy)),
		.b(recip_twelve), .done(sc_done_v[3]), .product(p_yy));
	ghs_sermul #(.AW(MW), .BW(RW)) u_mul_xy (
		.clk(clk), .arst_n(arst_n), .start(sc_start), .a(ghs_pkg::num_mag(q_num.nxy)),
		.b(recip_twelve >> 2), .done(sc_done_v[4]), .product(p_xy));

	// Squares of (fxx - fyy) and 2 fxy.
	assign d_w   = (SW+1)'(fxx_q) - (SW+1)'(fyy_q);
	assign m_w   = (SW+1)'(fxy_q) <<< 1;
	assign d_abs = d_w[SW] ? (SW+1)'(-d_w) : (SW+1)'(d_w);
	assign m_abs = m_w[SW] ? (SW+1)'(-m_w) : (SW+1)'(m_w);

	ghs_sermul #(.AW(QW), .BW(QW)) u_sq_d (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .a(d_abs[QW-1:0]), .b(d_abs[QW-1:0]),
		.done(sq_done_v[0]), .product(p_d));
	ghs_sermul #(.AW(QW), .BW(QW)) u_sq_m (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .a(m_abs[QW-1:0]), .b(m_abs[QW-1:0]),
		.done(sq_done_v[1]), .product(p_m));

	// Floor root of the sum of squares.
	assign rad_w = ghs_pkg::RAD_W'(p_d) + ghs_pkg::RAD_W'(p_m);

	ghs_isqrt #(.RT(TW)) u_root (
		.clk(clk), .arst_n(arst_n), .start(rt_start), .radicand((2*TW)'(rad_w)),
		.done(rt_done), .root(root));

	assign sc_done = &sc_done_v;
	assign sq_done = &sq_done_v;
	assign load    = (state_q == ghs_pkg::BK_DONE) && (!out_valid_q || out_ready);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ghs_pkg::BK_IDLE:   if (q_valid) state_d = ghs_pkg::BK_SCALE;
			ghs_pkg::BK_SCALE:  if (sc_done) state_d = ghs_pkg::BK_SQ_GO;
			ghs_pkg::BK_SQ_GO:  state_d = ghs_pkg::BK_SQUARE;
			ghs_pkg::BK_SQUARE: if (sq_done) state_d = ghs_pkg::BK_ROOT;
			ghs_pkg::BK_ROOT:   if (rt_done) state_d = ghs_pkg::BK_DONE;
			ghs_pkg::BK_DONE:   if (load) state_d = ghs_pkg::BK_IDLE;
			default:            state_d = ghs_pkg::BK_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		q_pop    = 1'b0;
		sc_start = 1'b0;
		sq_start = 1'b0;
		rt_start = 1'b0;
		unique case (state_q)
			ghs_pkg::BK_IDLE: begin
				q_pop    = q_valid;
				sc_start = q_valid;
			end
			ghs_pkg::BK_SQ_GO:  sq_start = 1'b1;
			ghs_pkg::BK_SQUARE: rt_start = sq_done;
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ghs_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign s_w = (SW+1)'(fxx_q) + (SW+1)'(fyy_q);

	// Job fields, scaled values and the result register.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			neg_q  <= {q_num.nxy[ghs_pkg::NUM_W-1], q_num.nyy[ghs_pkg::NUM_W-1],
				q_num.nxx[ghs_pkg::NUM_W-1], q_num.dy[ghs_pkg::NUM_W-1],
				q_num.dx[ghs_pkg::NUM_W-1]};
			row_q  <= q_row;
			col_q  <= q_col;
			last_q <= q_last;
		end
		if (state_q == ghs_pkg::BK_SCALE && sc_done) begin
			gx_q  <= ghs_pkg::scale_round(p_gx, neg_q[0]);
			gy_q  <= ghs_pkg::scale_round(p_gy, neg_q[1]);
			fxx_q <= ghs_pkg::scale_round(p_xx, neg_q[2]);
			fyy_q <= ghs_pkg::scale_round(p_yy, neg_q[3]);
			fxy_q <= ghs_pkg::scale_round(p_xy, neg_q[4]);
		end
		if (load) begin
			row        <= row_q;
			col        <= col_q;
			last_point <= last_q;
			grad_x     <= ghs_pkg::sat48(XW'(gx_q));
			grad_y     <= ghs_pkg::sat48(XW'(gy_q));
			eig_plus   <= ghs_pkg::sat48(XW'(s_w) + XW'(signed'({1'b0, root})));
			eig_minus  <= ghs_pkg::sat48(XW'(s_w) - XW'(signed'({1'b0, root})));
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/grid_gradient_hessian_stencil.sv =====
// Top level of the 5x5 gradient and Hessian-eigenvalue stencil.
// Depends on ghs_pkg, ghs_front, ghs_queue and ghs_back.
//
//   Port group   Handshake               Payload
//   input        in_valid / in_ready     sample
//   result       out_valid / out_ready   row, col, grad_x, grad_y, eig_plus, eig_minus,
//                                        last_point
//   config       cfg_wr_en               cfg_index, cfg_data
//
// After each sample the front end passes an update state, which writes the line store back
// after its registered read, and an evaluate state when the sample completes an interior window
// (it waits while the queue is full) before it takes the next. Each interior point then runs
// through the back end's reciprocal multiplies, squares and square root, one bit a cycle.
// A two-entry queue and the result register let the front end run ahead of the back end.
// Reset is asynchronous and active low; no clearing pass is needed after it.
`timescale 1ns / 1ps

module grid_gradient_hessian_stencil #(
	parameter int MAX_GRID = ghs_pkg::MAX_GRID_DEF,
	parameter int CW       = $clog2(MAX_GRID)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [ghs_pkg::SAMPLE_W-1:0]  sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [CW-1:0]                        row,
	output logic [CW-1:0]                        col,
	output logic signed [ghs_pkg::OUT_W-1:0]     grad_x,
	output logic signed [ghs_pkg::OUT_W-1:0]     grad_y,
	output logic signed [ghs_pkg::OUT_W-1:0]     eig_plus,
	output logic signed [ghs_pkg::OUT_W-1:0]     eig_minus,
	output logic                                 last_point,
	input  logic                                 cfg_wr_en,
	input  logic [ghs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ghs_pkg::RCP_W-1:0]            cfg_data
);

	localparam int NUMB = $bits(ghs_pkg::num_t);
	localparam int DW   = NUMB + 2 * CW + 1;

	logic [ghs_pkg::GS_W-1:0]  grid_size_q;
	logic [ghs_pkg::RCP_W-1:0] recip_two_q;
	logic [ghs_pkg::RCP_W-1:0] recip_twelve_q;

	logic          push, full, pop, nempty;
	ghs_pkg::num_t push_num, pop_num;
	logic [CW-1:0] push_row, push_col, pop_row, pop_col;
	logic          push_last, pop_last;
	logic [DW-1:0] push_data, pop_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q    <= ghs_pkg::GRID_RESET;
			recip_two_q    <= ghs_pkg::RECIP_TWO_RESET;
			recip_twelve_q <= ghs_pkg::RECIP_TWELVE_RESET;
		end else if (cfg_wr_en) begin
			unique case (ghs_pkg::cfg_idx_t'(cfg_index))
				ghs_pkg::CFG_GRID_SIZE:    grid_size_q    <= cfg_data[ghs_pkg::GS_W-1:0];
				ghs_pkg::CFG_RECIP_TWO:    recip_two_q    <= cfg_data;
				ghs_pkg::CFG_RECIP_TWELVE: recip_twelve_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front end: window and stencil sums.
	ghs_front #(.MAX_GRID(MAX_GRID), .CW(CW)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.sample(sample), .grid_size(grid_size_q), .push(push), .full(full),
		.push_num(push_num), .push_row(push_row), .push_col(push_col),
		.push_last(push_last));

	// Job queue between the two halves.
	assign push_data = {push_row, push_col, push_last, push_num};
	assign pop_num   = ghs_pkg::num_t'(pop_data[NUMB-1:0]);
	assign pop_last  = pop_data[NUMB];
	assign pop_col   = pop_data[NUMB+1 +: CW];
	assign pop_row   = pop_data[NUMB+1+CW +: CW];

	ghs_queue #(.DW(DW), .DEPTH(ghs_pkg::QDEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data), .full(full),
		.pop(pop), .pop_data(pop_data), .nempty(nempty));

	// Back end: scaling, root and results.
	ghs_back #(.CW(CW)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(nempty), .q_pop(pop), .q_num(pop_num),
		.q_row(pop_row), .q_col(pop_col), .q_last(pop_last),
		.recip_two(recip_two_q), .recip_twelve(recip_twelve_q),
		.out_valid(out_valid), .out_ready(out_ready), .row(row), .col(col),
		.grad_x(grad_x), .grad_y(grad_y), .eig_plus(eig_plus), .eig_minus(eig_minus),
		.last_point(last_point));

endmodule
